// ===== sv/bale_pkg.sv =====
package bale_pkg;

	localparam int BALE_CAPACITY    = 64;
	localparam int BALE_HANDLE_BITS = 32;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_REMOVE = 3'd1;
	localparam logic [2:0] ACT_FIND   = 3'd2;
	localparam logic [2:0] ACT_READ   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  position;
		logic [31:0] handle_in;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] handle_out;
		logic [5:0]  found_position;
		logic [6:0]  entry_count;
		logic        is_empty;
		logic        is_full;
		logic [31:0] first_handle;
		logic [31:0] last_handle;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_INS_WR,
		ST_EDGE0,
		ST_EDGE1,
		ST_EDGE2,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		PTR_ZERO,
		PTR_POS,
		PTR_LAST
	} ptr_sel_t;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_MAIN,
		RK_FIRST,
		RK_LAST
	} rd_kind_t;

	typedef struct packed {
		logic     accept;
		logic     decide;
		logic     ptr_load;
		ptr_sel_t ptr_sel;
		logic     ptr_inc;
		logic     ptr_dec;
		rd_kind_t rd_kind;
		logic     ins_wr;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     cnt_clr;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic is_ins;
		logic is_rm;
		logic is_find;
		logic is_rd;
		logic is_clr;
		logic ins_ok;
		logic rm_ok;
		logic pos_eq_cnt;
		logic cnt_zero;
		logic ptr_eq_pos;
		logic ptr_eq_last;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/bounded_array_list_engine.sv =====
// Clear, refused and unknown requests and an insert at the tail skip the walk; remove and find
// walk the store upwards to the last entry, a shifting insert walks downwards to the request
// position and read takes one entry, all on the single memory read port. Then the first and last
// handles are read, the result is loaded, and only then is a request taken, also while it waits.
// Reset: arst_n clears the count, the controller and the result valid; the store itself is
// not cleared and needs no clearing pass, since only positions below the count are read.
module bounded_array_list_engine
	import bale_pkg::*;
#(
	parameter int CAPACITY    = BALE_CAPACITY,
	parameter int HANDLE_BITS = BALE_HANDLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// The controller sequences each request through decision, a walk over the store,
	// a final handle write for inserts, two reads for the first and last handles and
	// the load of the result register. It sees the datapath only through status flags.
	cmd_t cmd;
	sts_t sts;

	bale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the store as a single-port-read, single-port-write memory,
	// the entry count, the walk pointer and the result register. A read issued in one
	// cycle is acted upon in the next: shifted up or down, compared or captured.
	bale_dp #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== sv/bale_ctrl.sv =====
module bale_ctrl
	import bale_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   walk_last;

	// Insert walks downwards to the request position; read takes one entry;
	// remove and find walk upwards to the last entry.
	always_comb begin
		if (sts.is_ins) begin
			walk_last = sts.ptr_eq_pos;
		end else if (sts.is_rd) begin
			walk_last = 1'b1;
		end else begin
			walk_last = sts.ptr_eq_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (sts.is_ins && sts.ins_ok) begin
					state_d = sts.pos_eq_cnt ? ST_INS_WR : ST_WALK;
				end else if (sts.is_rm && sts.rm_ok) begin
					state_d = ST_WALK;
				end else if (sts.is_find && !sts.cnt_zero) begin
					state_d = ST_WALK;
				end else if (sts.is_rd && sts.rm_ok) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_EDGE0;
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = sts.is_ins ? ST_INS_WR : ST_EDGE0;
			end
			ST_INS_WR: state_d = ST_EDGE0;
			ST_EDGE0:  state_d = ST_EDGE1;
			ST_EDGE1:  state_d = ST_EDGE2;
			ST_EDGE2:  state_d = ST_RESP;
			ST_RESP: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.ptr_sel = PTR_ZERO;
		cmd.rd_kind = RK_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				priority if (sts.is_ins && sts.ins_ok) begin
					cmd.ptr_load = !sts.pos_eq_cnt;
					cmd.ptr_sel  = PTR_LAST;
				end else if (sts.is_rm && sts.rm_ok) begin
					cmd.ptr_load = 1'b1;
					cmd.ptr_sel  = PTR_POS;
				end else if (sts.is_find && !sts.cnt_zero) begin
					cmd.ptr_load = 1'b1;
					cmd.ptr_sel  = PTR_ZERO;
				end else if (sts.is_rd && sts.rm_ok) begin
					cmd.ptr_load = 1'b1;
					cmd.ptr_sel  = PTR_POS;
				end else begin
					cmd.cnt_clr = sts.is_clr;
				end
			end
			ST_WALK: begin
				cmd.rd_kind = RK_MAIN;
				cmd.ptr_dec = !walk_last && sts.is_ins;
				cmd.ptr_inc = !walk_last && !sts.is_ins;
			end
			ST_DRAIN: begin
				cmd.cnt_dec = sts.is_rm;
			end
			ST_INS_WR: begin
				cmd.ins_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_EDGE0: cmd.rd_kind = RK_FIRST;
			ST_EDGE1: cmd.rd_kind = RK_LAST;
			ST_EDGE2: cmd.rd_kind = RK_NONE;
			ST_RESP: begin
				cmd.out_load = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/bale_dp.sv =====
module bale_dp
	import bale_pkg::*;
#(
	parameter int CAPACITY    = BALE_CAPACITY,
	parameter int HANDLE_BITS = BALE_HANDLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	logic [HANDLE_BITS-1:0] mem [CAPACITY];

	logic [2:0]             act_q;
	logic [6:0]             pos_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          ptr_q;
	logic [HANDLE_BITS-1:0] rdata_s1;
	logic [AW-1:0]          tag_s1;
	rd_kind_t               rk_s1;
	logic                   ok_q;
	logic [HANDLE_BITS-1:0] hout_q;
	logic [AW-1:0]          fpos_q;
	logic [HANDLE_BITS-1:0] first_q;
	logic [HANDLE_BITS-1:0] last_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic [PW-1:0]          pos_x;
	logic [PW-1:0]          cnt_x;
	logic [AW-1:0]          pos_a;
	logic [AW-1:0]          last_addr;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [HANDLE_BITS-1:0] wdata;
	logic                   arr_main;
	logic                   arr_at_pos;
	logic                   req_ok;

	assign pos_x     = PW'(pos_q);
	assign cnt_x     = PW'(cnt_q);
	assign pos_a     = AW'(pos_q);
	assign last_addr = (cnt_q == '0) ? '0 : AW'(cnt_q - CW'(1));

	assign sts.is_ins      = (act_q == ACT_INSERT);
	assign sts.is_rm       = (act_q == ACT_REMOVE);
	assign sts.is_find     = (act_q == ACT_FIND);
	assign sts.is_rd       = (act_q == ACT_READ);
	assign sts.is_clr      = (act_q == ACT_CLEAR);
	assign sts.ins_ok      = (cnt_q != CW'(CAPACITY)) && (pos_x <= cnt_x);
	assign sts.rm_ok       = (pos_x < cnt_x);
	assign sts.pos_eq_cnt  = (pos_x == cnt_x);
	assign sts.cnt_zero    = (cnt_q == '0);
	assign sts.ptr_eq_pos  = (ptr_q == pos_a);
	assign sts.ptr_eq_last = (ptr_q == last_addr);
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

	assign req_ok = (sts.is_ins && sts.ins_ok) || (sts.is_rm && sts.rm_ok) ||
	                (sts.is_rd && sts.rm_ok) || sts.is_clr;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= req.action;
			pos_q <= req.position;
			h_q   <= HANDLE_BITS'(req.handle_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_load) begin
			unique case (cmd.ptr_sel)
				PTR_ZERO: ptr_q <= '0;
				PTR_POS:  ptr_q <= pos_a;
				PTR_LAST: ptr_q <= last_addr;
				default:  ptr_q <= '0;
			endcase
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end
	end

	always_comb begin
		unique case (cmd.rd_kind)
			RK_MAIN: raddr = ptr_q;
			RK_LAST: raddr = last_addr;
			default: raddr = '0;
		endcase
	end

	// Data read in the previous cycle arrives here with its address tag.
	assign arr_main   = (rk_s1 == RK_MAIN);
	assign arr_at_pos = (tag_s1 == pos_a);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_s1;
		priority if (cmd.ins_wr) begin
			we    = 1'b1;
			waddr = pos_a;
			wdata = h_q;
		end else if (arr_main && sts.is_ins) begin
			we    = 1'b1;
			waddr = tag_s1 + AW'(1);
		end else if (arr_main && sts.is_rm && !arr_at_pos) begin
			we    = 1'b1;
			waddr = tag_s1 - AW'(1);
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
		tag_s1   <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_s1 <= RK_NONE;
		end else begin
			rk_s1 <= cmd.rd_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			ok_q   <= req_ok;
			hout_q <= '0;
			fpos_q <= '0;
		end else if (arr_main) begin
			if (sts.is_rd || (sts.is_rm && arr_at_pos)) begin
				hout_q <= rdata_s1;
			end
			if (sts.is_find && !ok_q && (rdata_s1 == h_q)) begin
				ok_q   <= 1'b1;
				fpos_q <= tag_s1;
			end
		end
		if (rk_s1 == RK_FIRST) begin
			first_q <= rdata_s1;
		end
		if (rk_s1 == RK_LAST) begin
			last_q <= rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.ok             <= ok_q;
			rsp_q.handle_out     <= 32'(hout_q);
			rsp_q.found_position <= 6'(fpos_q);
			rsp_q.entry_count    <= 7'(cnt_q);
			rsp_q.is_empty       <= (cnt_q == '0);
			rsp_q.is_full        <= (cnt_q == CW'(CAPACITY));
			rsp_q.first_handle   <= (cnt_q == '0) ? 32'd0 : 32'(first_q);
			rsp_q.last_handle    <= (cnt_q == '0) ? 32'd0 : 32'(last_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (rk_s1 != RK_MAIN))
		else $error("handle write collides with a shift write");

	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cnt_q != CW'(CAPACITY)))
		else $error("insert committed on a full list");

	a_dec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (cnt_q != '0))
		else $error("remove committed on an empty list");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!$past(cmd.out_load) && (!rsp_valid_q || rsp_ready)))
		else $error("result register overwritten before it was taken");
`endif

endmodule
